/* design/mbg_pkg.sv */
// Shared constants, types and helper functions of the maze generator.
`default_nettype none
package mbg_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int STACK_DEPTH = 1024;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CELL_W = ROW_W + COL_W;
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W  = SP_W + 1;

  localparam int DIM_W = 7;
  localparam int RND_W = 16;
  localparam int OUT_ROW_W = 6;
  localparam int OUT_COL_W = 6;

  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int WALL_W  = $clog2(MAX_DIM / 2 + 1);
  localparam int DIV_W   = $clog2(MAX_DIM / 2 + 1);
  localparam int ITER_W  = $clog2(RND_W + 1);

  // floor(n / 5) as (n * 205) >> 10, exact for the clamped dimensions
  localparam int RECIP    = 205;
  localparam int RECIP_W  = 8;
  localparam int RECIP_SH = 10;
  localparam int OPEN_SAT = 15;
  localparam int OPEN_W   = 4;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b1;
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd32;

  typedef enum logic [1:0] {
    PH_WALK,
    PH_RIGHT,
    PH_BOTTOM
  } step_phase_e;

  typedef enum logic [1:0] {
    OUT_FORWARD,
    OUT_BACK,
    OUT_RIGHT,
    OUT_BOTTOM
  } out_phase_e;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_UP,
    ST_RD_DN,
    ST_RD_ROW,
    ST_EVAL,
    ST_POP,
    ST_DIV_GO,
    ST_DIV,
    ST_EDGE_RD,
    ST_EDGE_EVAL
  } state_e;

  typedef struct packed {
    logic             re;
    logic [ROW_W-1:0] addr;
  } bm_rd_t;

  typedef struct packed {
    logic                we;
    logic [ROW_W-1:0]    addr;
    logic [MAX_COLS-1:0] data;
    logic [MAX_COLS-1:0] mask;
  } bm_wr_t;

  // v mod 3: base-4 digits sum to the same residue
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < RND_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[4]) + 3'(s[3:2]) + 3'(s[1:0]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  function automatic logic [OPEN_W-1:0] open_count(input logic [DIM_W-1:0] n);
    logic [DIM_W+RECIP_W-1:0] p;
    p = (DIM_W + RECIP_W)'(n) * (DIM_W + RECIP_W)'(RECIP);
    p = p >> RECIP_SH;
    return (p > (DIM_W + RECIP_W)'(OPEN_SAT)) ? OPEN_W'(OPEN_SAT) : OPEN_W'(p);
  endfunction

endpackage
`default_nettype wire

/* design/mbg_if.sv */
// Request and result channel interfaces of the maze generator.
`default_nettype none
interface mbg_in_if;
  import mbg_pkg::*;
  logic             valid;
  logic             ready;
  logic [RND_W-1:0] random_value;
  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

interface mbg_out_if;
  import mbg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 carved;
  logic [OUT_ROW_W-1:0] carved_row;
  logic [OUT_COL_W-1:0] carved_col;
  logic [1:0]           phase;
  logic                 done_res;
  modport source (output valid, output carved, output carved_row, output carved_col,
                  output phase, output done_res, input ready);
  modport sink (input valid, input carved, input carved_row, input carved_col,
                input phase, input done_res, output ready);
endinterface
`default_nettype wire

/* design/mbg_bitmap.sv */
// One-bit-per-cell grid map, one row per word, bit-masked write, registered read.
`default_nettype none
module mbg_bitmap (
  input  logic                         clk_i,
  input  mbg_pkg::bm_rd_t              rd_i,
  output logic [mbg_pkg::MAX_COLS-1:0] rd_data_o,
  input  mbg_pkg::bm_wr_t              wr_i
);
  import mbg_pkg::*;

  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      for (int b = 0; b < MAX_COLS; b++) begin
        if (wr_i.mask[b]) begin
          mem_q[wr_i.addr][b] <= wr_i.data[b];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

/* design/mbg_stack.sv */
// Path stack of walked cells, one write and one registered read per cycle.
`default_nettype none
module mbg_stack (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [mbg_pkg::SP_W-1:0]   waddr_i,
  input  logic [mbg_pkg::CELL_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [mbg_pkg::SP_W-1:0]   raddr_i,
  output logic [mbg_pkg::CELL_W-1:0] rdata_o
);
  import mbg_pkg::*;

  logic [CELL_W-1:0] mem_q [STACK_DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* design/mbg_mod.sv */
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module mbg_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mbg_pkg::RND_W-1:0] dividend_i,
  input  logic [mbg_pkg::DIV_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [mbg_pkg::DIV_W-1:0] rem_o
);
  import mbg_pkg::*;

  logic              busy_q, busy_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [RND_W-1:0]  dvd_q, dvd_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    iter_d = iter_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[RND_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = ITER_W'(RND_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in the next bit, subtract when it fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DIV_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = DIV_W'(trial);
      end
      dvd_d  = dvd_q << 1;
      iter_d = iter_q - ITER_W'(1);
      busy_d = (iter_q != ITER_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

/* design/maze_backtracker_generator_unit.sv */
// Maze generator top level: sequencer, grid maps, path stack and remainder unit.
//
// Usage: each request on req_i carries one 16-bit random word and yields exactly
// one result on rsp_o (carved flag, carved cell, phase, done flag). Grid height
// and width are written on the cfg port (index 0 height, index 1 width); the user
// must write them while the block is idle (not enforced); every write restarts the maze.
// Steps: a forward step makes three visited-map row reads, then the evaluation;
// a backtrack step adds a path-stack read. An edge opening step runs the
// bit-serial remainder unit, then one road-map read; the step that ends the
// walk makes the row reads, then the first edge attempt.
// One request is in work at a time; the next is taken once the result is
// registered.
// Reset and restart: after reset, after a cfg write and after the result that
// finishes the maze, both grid maps are cleared one row per cycle;
// req_i.ready stays low meanwhile.
// Stall: a result waits in the output register while rsp_o.ready is low; the
// emitting state holds, and its map, stack and position writes wait for the slot.
`default_nettype none
module maze_backtracker_generator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mbg_in_if.sink                        req_i,
  mbg_out_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [mbg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mbg_pkg::DIM_W-1:0]     cfg_data_i
);
  import mbg_pkg::*;

  state_e            state_q, state_d;
  step_phase_e       phase_q, phase_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [OPEN_W-1:0] left_q, left_d;
  logic [WALL_W-1:0] walls_q, walls_d;
  logic [RND_W-1:0]  rnd_q, rnd_d;
  logic              up_free_q, up_free_d;
  logic              dn_free_q, dn_free_d;
  logic              clr_act_q, clr_act_d;
  logic [ROW_W-1:0]  clr_row_q, clr_row_d;
  logic [DIM_W-1:0]  h_q, h_d, w_q, w_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_carved_q, out_carved_d;
  logic [OUT_ROW_W-1:0] out_row_q, out_row_d;
  logic [OUT_COL_W-1:0] out_col_q, out_col_d;
  out_phase_e           out_phase_q, out_phase_d;
  logic                 out_done_q, out_done_d;

  logic [DIM_W-1:0]  h_u, w_u;
  logic [OPEN_W-1:0] rleft, bleft;
  logic [WALL_W-1:0] rwall, bwall;
  logic              right_ok, bottom_ok;

  bm_rd_t              vis_rd, road_rd;
  bm_wr_t              vis_wr, road_wr;
  logic [MAX_COLS-1:0] vis_data, road_data;

  logic              stk_we, stk_re;
  logic [SP_W-1:0]   stk_raddr;
  logic [CELL_W-1:0] stk_rdata;

  logic             mod_start, mod_busy;
  logic [DIV_W-1:0] mod_div, mod_rem;

  logic             req_acc, emit_ok;
  logic [DIM_W-1:0] row_p2, col_p2;
  logic             lf_free, rt_free;
  logic [3:0]       free_v;
  logic [2:0]       ncnt;
  logic [1:0]       pick;
  dir_e             dir;
  logic [ROW_W-1:0] nr, mr, er;
  logic [COL_W-1:0] nc, mc, ec;
  logic             edge_road;

  // ---------------- dimensions and edge-phase counts ----------------
  always_comb begin
    h_u = h_q;
    w_u = w_q;
    if (h_q < DIM_W'(2)) h_u = DIM_W'(2);
    if (h_q > DIM_W'(MAX_ROWS)) h_u = DIM_W'(MAX_ROWS);
    if (w_q < DIM_W'(2)) w_u = DIM_W'(2);
    if (w_q > DIM_W'(MAX_COLS)) w_u = DIM_W'(MAX_COLS);
  end

  // a right-column candidate is wall only when that column is odd, same for the bottom row
  assign rleft     = open_count(h_u);
  assign bleft     = open_count(w_u);
  assign rwall     = w_u[0] ? '0 : WALL_W'(h_u >> 1);
  assign bwall     = h_u[0] ? '0 : WALL_W'(w_u >> 1);
  assign right_ok  = (rleft != '0) && (rwall != '0);
  assign bottom_ok = (bleft != '0) && (bwall != '0);

  // ---------------- walk step evaluation ----------------
  assign req_acc = req_i.valid && req_i.ready;
  assign emit_ok = !out_valid_q || rsp_o.ready;
  assign row_p2  = DIM_W'(row_q) + DIM_W'(2);
  assign col_p2  = DIM_W'(col_q) + DIM_W'(2);

  assign lf_free = (col_q >= COL_W'(2)) &&
                   !(vis_data[COL_W'(col_q - COL_W'(2))] ||
                     ((row_q == '0) && (col_q == COL_W'(2))));
  assign rt_free = (col_p2 < w_u) && !vis_data[COL_W'(col_p2)];
  assign free_v  = {rt_free, lf_free, dn_free_q, up_free_q};
  assign ncnt    = 3'(free_v[0]) + 3'(free_v[1]) + 3'(free_v[2]) + 3'(free_v[3]);

  always_comb begin
    case (ncnt)
      3'd2:    pick = {1'b0, rnd_q[0]};
      3'd3:    pick = mod3(rnd_q);
      3'd4:    pick = rnd_q[1:0];
      default: pick = 2'd0;
    endcase
  end

  // pick-th free neighbor in the order up, down, left, right
  always_comb begin
    logic [2:0] seen;
    seen = '0;
    dir  = DIR_UP;
    for (int d = 0; d < 4; d++) begin
      if (free_v[d]) begin
        if (seen == 3'(pick)) dir = dir_e'(2'(d));
        seen = seen + 3'd1;
      end
    end
  end

  always_comb begin
    nr = row_q;
    mr = row_q;
    nc = col_q;
    mc = col_q;
    case (dir)
      DIR_UP: begin
        nr = row_q - ROW_W'(2);
        mr = row_q - ROW_W'(1);
      end
      DIR_DOWN: begin
        nr = row_q + ROW_W'(2);
        mr = row_q + ROW_W'(1);
      end
      DIR_LEFT: begin
        nc = col_q - COL_W'(2);
        mc = col_q - COL_W'(1);
      end
      DIR_RIGHT: begin
        nc = col_q + COL_W'(2);
        mc = col_q + COL_W'(1);
      end
      default: begin
        nr = row_q;
      end
    endcase
  end

  // ---------------- edge attempt cell ----------------
  assign mod_div   = (phase_q == PH_RIGHT) ? DIV_W'(h_u >> 1) : DIV_W'(w_u >> 1);
  assign er        = (phase_q == PH_RIGHT) ? ROW_W'({mod_rem, 1'b0}) : ROW_W'(h_u - DIM_W'(1));
  assign ec        = (phase_q == PH_RIGHT) ? COL_W'(w_u - DIM_W'(1)) : COL_W'({mod_rem, 1'b0});
  assign edge_road = road_data[ec] || (!er[0] && !ec[0]);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) state_d = (phase_q == PH_WALK) ? ST_RD_UP : ST_DIV_GO;
      end
      ST_RD_UP:  state_d = ST_RD_DN;
      ST_RD_DN:  state_d = ST_RD_ROW;
      ST_RD_ROW: state_d = ST_EVAL;
      ST_EVAL: begin
        if (ncnt != '0) begin
          if (emit_ok) state_d = ST_IDLE;
        end else if (cnt_q != '0) begin
          state_d = ST_POP;
        end else if (right_ok || bottom_ok) begin
          state_d = ST_DIV_GO;
        end else if (emit_ok) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        if (emit_ok) state_d = ST_IDLE;
      end
      ST_DIV_GO: state_d = ST_DIV;
      ST_DIV: begin
        if (!mod_busy) state_d = ST_EDGE_RD;
      end
      ST_EDGE_RD: state_d = ST_EDGE_EVAL;
      ST_EDGE_EVAL: begin
        if (emit_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- datapath and memory requests ----------------
  always_comb begin
    logic             emit, clr_start;
    logic [OPEN_W-1:0] nl;
    logic [WALL_W-1:0] nw;
    emit      = 1'b0;
    clr_start = 1'b0;
    nl        = left_q;
    nw        = walls_q;

    phase_d   = phase_q;
    row_d     = row_q;
    col_d     = col_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    walls_d   = walls_q;
    rnd_d     = rnd_q;
    up_free_d = up_free_q;
    dn_free_d = dn_free_q;
    clr_act_d = clr_act_q;
    clr_row_d = clr_row_q;
    h_d       = h_q;
    w_d       = w_q;

    out_carved_d = 1'b0;
    out_row_d    = '0;
    out_col_d    = '0;
    out_phase_d  = OUT_FORWARD;
    out_done_d   = 1'b0;

    vis_rd    = '0;
    road_rd   = '0;
    vis_wr    = '0;
    road_wr   = '0;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_raddr = '0;
    mod_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_acc) rnd_d = req_i.random_value;
      end
      ST_RD_UP: begin
        vis_rd = '{re: 1'b1, addr: ROW_W'(row_q - ROW_W'(2))};
      end
      ST_RD_DN: begin
        up_free_d = (row_q >= ROW_W'(2)) &&
                    !(vis_data[col_q] || ((row_q == ROW_W'(2)) && (col_q == '0)));
        vis_rd = '{re: 1'b1, addr: ROW_W'(row_p2)};
      end
      ST_RD_ROW: begin
        dn_free_d = (row_p2 < h_u) && !vis_data[col_q];
        vis_rd = '{re: 1'b1, addr: row_q};
      end
      ST_EVAL: begin
        if (ncnt != '0) begin
          if (emit_ok) begin
            emit         = 1'b1;
            out_carved_d = 1'b1;
            out_row_d    = OUT_ROW_W'(mr);
            out_col_d    = OUT_COL_W'(mc);
            vis_wr  = '{we: 1'b1, addr: nr, data: '1, mask: MAX_COLS'(1) << nc};
            road_wr = '{we: 1'b1, addr: mr, data: '1, mask: MAX_COLS'(1) << mc};
            // drop the push when the stack is full
            if (cnt_q < CNT_W'(STACK_DEPTH)) begin
              stk_we = 1'b1;
              cnt_d  = cnt_q + CNT_W'(1);
            end
            row_d = nr;
            col_d = nc;
          end
        end else if (cnt_q != '0) begin
          stk_re    = 1'b1;
          stk_raddr = SP_W'(cnt_q - CNT_W'(1));
          cnt_d     = cnt_q - CNT_W'(1);
        end else if (right_ok) begin
          phase_d = PH_RIGHT;
          left_d  = rleft;
          walls_d = rwall;
        end else if (bottom_ok) begin
          phase_d = PH_BOTTOM;
          left_d  = bleft;
          walls_d = bwall;
        end else if (emit_ok) begin
          emit        = 1'b1;
          out_phase_d = OUT_BOTTOM;
          out_done_d  = 1'b1;
          clr_start   = 1'b1;
        end
      end
      ST_POP: begin
        if (emit_ok) begin
          emit         = 1'b1;
          out_phase_d  = OUT_BACK;
          {row_d, col_d} = stk_rdata;
        end
      end
      ST_DIV_GO: begin
        mod_start = 1'b1;
      end
      ST_EDGE_RD: begin
        road_rd = '{re: 1'b1, addr: er};
      end
      ST_EDGE_EVAL: begin
        if (emit_ok) begin
          emit        = 1'b1;
          out_phase_d = (phase_q == PH_RIGHT) ? OUT_RIGHT : OUT_BOTTOM;
          if (!edge_road) begin
            road_wr = '{we: 1'b1, addr: er, data: '1, mask: MAX_COLS'(1) << ec};
            nl = left_q - OPEN_W'(1);
            nw = walls_q - WALL_W'(1);
            out_carved_d = 1'b1;
            out_row_d    = OUT_ROW_W'(er);
            out_col_d    = OUT_COL_W'(ec);
          end
          if ((nl == '0) || (nw == '0)) begin
            if ((phase_q == PH_RIGHT) && bottom_ok) begin
              phase_d = PH_BOTTOM;
              left_d  = bleft;
              walls_d = bwall;
            end else begin
              out_done_d = 1'b1;
              clr_start  = 1'b1;
            end
          end else begin
            left_d  = nl;
            walls_d = nw;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HEIGHT: h_d = cfg_data_i;
        CFG_WIDTH:  w_d = cfg_data_i;
        default:    h_d = h_q;
      endcase
      clr_start = 1'b1;
    end

    // clearing pass owns both map write ports
    if (clr_act_q) begin
      vis_wr  = '{we: 1'b1, addr: clr_row_q, data: '0, mask: '1};
      road_wr = '{we: 1'b1, addr: clr_row_q, data: '0, mask: '1};
      clr_row_d = clr_row_q + ROW_W'(1);
      if (clr_row_q == ROW_W'(MAX_ROWS - 1)) clr_act_d = 1'b0;
    end

    if (clr_start) begin
      clr_act_d = 1'b1;
      clr_row_d = '0;
      row_d     = '0;
      col_d     = '0;
      cnt_d     = '0;
      phase_d   = PH_WALK;
      left_d    = '0;
      walls_d   = '0;
    end

    out_valid_d = emit || (out_valid_q && !rsp_o.ready);
    if (!emit) begin
      out_carved_d = out_carved_q;
      out_row_d    = out_row_q;
      out_col_d    = out_col_q;
      out_phase_d  = out_phase_q;
      out_done_d   = out_done_q;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_WALK;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      left_q      <= '0;
      walls_q     <= '0;
      clr_act_q   <= 1'b1;
      clr_row_q   <= '0;
      h_q         <= DIM_RESET;
      w_q         <= DIM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      walls_q     <= walls_d;
      clr_act_q   <= clr_act_d;
      clr_row_q   <= clr_row_d;
      h_q         <= h_d;
      w_q         <= w_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q        <= rnd_d;
    up_free_q    <= up_free_d;
    dn_free_q    <= dn_free_d;
    out_carved_q <= out_carved_d;
    out_row_q    <= out_row_d;
    out_col_q    <= out_col_d;
    out_phase_q  <= out_phase_d;
    out_done_q   <= out_done_d;
  end

  // ---------------- storage and units ----------------
  mbg_bitmap u_visited (
    .clk_i     (clk_i),
    .rd_i      (vis_rd),
    .rd_data_o (vis_data),
    .wr_i      (vis_wr)
  );

  mbg_bitmap u_road (
    .clk_i     (clk_i),
    .rd_i      (road_rd),
    .rd_data_o (road_data),
    .wr_i      (road_wr)
  );

  mbg_stack u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (cnt_q[SP_W-1:0]),
    .wdata_i ({row_q, col_q}),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  mbg_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rnd_q),
    .divisor_i  (mod_div),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  assign req_i.ready      = (state_q == ST_IDLE) && !clr_act_q;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.carved     = out_carved_q;
  assign rsp_o.carved_row = out_row_q;
  assign rsp_o.carved_col = out_col_q;
  assign rsp_o.phase      = out_phase_q;
  assign rsp_o.done_res   = out_done_q;

endmodule
`default_nettype wire

/* design/mbg_checker.sv */
// Port-level assertions for the maze generator and their bind to the top level.
`default_nettype none
module mbg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic                           carved_i,
  input logic [mbg_pkg::OUT_ROW_W-1:0]  carved_row_i,
  input logic [mbg_pkg::OUT_COL_W-1:0]  carved_col_i,
  input logic [1:0]                     phase_i,
  input logic                           done_res_i
);
  import mbg_pkg::*;

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_no_carve_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !carved_i |-> (carved_row_i == '0) && (carved_col_i == '0))
    else $error("cell reported without carve");

  a_done_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && done_res_i |-> (phase_i == OUT_RIGHT) || (phase_i == OUT_BOTTOM))
    else $error("done outside edge phases");

  a_back_no_carve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (phase_i == OUT_BACK) |-> !carved_i)
    else $error("backtrack carved a cell");

  // a walk carve always lands between two even cells
  a_fwd_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && carved_i && (phase_i == OUT_FORWARD) |-> carved_row_i[0] ^ carved_col_i[0])
    else $error("walk carve not on a wall between cells");

endmodule

bind maze_backtracker_generator_unit mbg_checker u_mbg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .carved_i     (rsp_o.carved),
  .carved_row_i (rsp_o.carved_row),
  .carved_col_i (rsp_o.carved_col),
  .phase_i      (rsp_o.phase),
  .done_res_i   (rsp_o.done_res)
);
`default_nettype wire
